FILE: rtl/h264fua_pkg.sv
// Shared types and constants for the H.264 FU-A packetizer.
`default_nettype none
package h264fua_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0]  FU_A_TYPE = 8'd28;
    localparam logic [7:0]  NRI_MASK  = 8'hE0;
    localparam logic [7:0]  TYPE_MASK = 8'h1F;
    localparam logic [7:0]  START_BIT = 8'h80;
    localparam logic [7:0]  END_BIT   = 8'h40;
    localparam logic [13:0] MIN_PAYLOAD = 14'd3;

    localparam logic [13:0] MAX_PAYLOAD_RESET  = 14'd1400;
    localparam logic [6:0]  HEADER_BYTES_RESET = 7'd16;

    localparam logic REG_MAX_PAYLOAD  = 1'b0;
    localparam logic REG_HEADER_BYTES = 1'b1;

    typedef struct packed {
        logic        triple;
        logic [7:0]  ind;
        logic [7:0]  hdr;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        mark;
        logic [13:0] size;
        logic [31:0] ts;
        logic [7:0]  ftype;
        logic        chan;
    } entry_t;

endpackage
`default_nettype wire

FILE: rtl/h264fua_front.sv
// Front end: tracks NAL and fragment state and classifies each input byte.
`default_nettype none
module h264fua_front #(
    parameter int LENGTH_BITS = h264fua_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            nal_byte,
    input  wire logic                  first_of_frame,
    input  wire logic [23:0]           frame_length,
    input  wire logic [31:0]           timestamp,
    input  wire logic [7:0]            frame_type,
    input  wire logic                  channel,
    input  wire logic [13:0]           max_payload,
    output logic                       push,
    output h264fua_pkg::entry_t        entry
);
    import h264fua_pkg::*;

    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic                   frag_reg, frag_next;
    logic [7:0]             fu_ind_reg, fu_ind_next;
    logic [7:0]             fu_hdr_reg, fu_hdr_next;
    logic [13:0]            fill_reg, fill_next;
    logic [31:0]            ts_reg, ts_next;
    logic [7:0]             type_reg, type_next;
    logic                   chan_reg, chan_next;
    logic [13:0]            size_reg, size_next;

    logic [13:0]            maxp;
    logic [LENGTH_BITS-1:0] len_raw, len;
    logic [LENGTH_BITS-1:0] bl_dec;
    logic                   more;
    logic [13:0]            chunk;
    logic [13:0]            fill_cur, fill_dec;
    logic [7:0]             hdr_cur;

    always_comb
    begin
        maxp     = (max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload;
        len_raw  = LENGTH_BITS'(frame_length);
        len      = (len_raw == '0) ? LENGTH_BITS'(1) : len_raw;
        bl_dec   = bytes_left_reg - LENGTH_BITS'(1);
        more     = ({1'b0, bytes_left_reg} + (LENGTH_BITS+1)'(2))
                   > (LENGTH_BITS+1)'(maxp);
        chunk    = more ? (maxp - 14'd2) : bytes_left_reg[13:0];
        fill_cur = (fill_reg == '0) ? chunk : fill_reg;
        fill_dec = fill_cur - 14'd1;
        hdr_cur  = (fill_reg == '0) ? (fu_hdr_reg | (more ? 8'h00 : END_BIT)) : fu_hdr_reg;

        bytes_left_next = bytes_left_reg;
        frag_next       = frag_reg;
        fu_ind_next     = fu_ind_reg;
        fu_hdr_next     = fu_hdr_reg;
        fill_next       = fill_reg;
        ts_next         = ts_reg;
        type_next       = type_reg;
        chan_next       = chan_reg;
        size_next       = size_reg;
        push            = 1'b0;

        if (accept)
        begin
            if (first_of_frame)
            begin
                ts_next   = timestamp;
                type_next = frame_type;
                chan_next = channel;
                fill_next = '0;
                bytes_left_next = len - LENGTH_BITS'(1);
                if (len <= LENGTH_BITS'(maxp))
                begin
                    frag_next = 1'b0;
                    size_next = len[13:0];
                    push      = 1'b1;
                end
                else
                begin
                    frag_next   = 1'b1;
                    fu_ind_next = (nal_byte & NRI_MASK) | FU_A_TYPE;
                    fu_hdr_next = START_BIT | (nal_byte & TYPE_MASK);
                end
            end
            else if (bytes_left_reg != '0)
            begin
                push            = 1'b1;
                bytes_left_next = bl_dec;
                if (frag_reg)
                begin
                    if (fill_reg == '0)
                    begin
                        size_next   = chunk + 14'd2;
                        fu_hdr_next = hdr_cur & ~START_BIT;
                    end
                    fill_next = fill_dec;
                    if (bl_dec == '0)
                    begin
                        frag_next = 1'b0;
                        fill_next = '0;
                    end
                end
            end
        end

        entry.triple = 1'b0;
        entry.ind    = fu_ind_reg;
        entry.hdr    = hdr_cur;
        entry.data   = nal_byte;
        entry.first  = 1'b0;
        entry.last   = (bl_dec == '0);
        entry.mark   = 1'b1;
        entry.size   = size_next;
        entry.ts     = ts_next;
        entry.ftype  = type_next;
        entry.chan   = chan_next;
        if (first_of_frame)
        begin
            entry.first = 1'b1;
            entry.last  = (len == LENGTH_BITS'(1));
        end
        else if (frag_reg)
        begin
            entry.triple = (fill_reg == '0);
            entry.last   = (fill_dec == '0);
            entry.mark   = (hdr_cur & END_BIT) != 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            frag_reg       <= 1'b0;
            fu_ind_reg     <= '0;
            fu_hdr_reg     <= '0;
            fill_reg       <= '0;
            ts_reg         <= '0;
            type_reg       <= '0;
            chan_reg       <= 1'b0;
            size_reg       <= '0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            frag_reg       <= frag_next;
            fu_ind_reg     <= fu_ind_next;
            fu_hdr_reg     <= fu_hdr_next;
            fill_reg       <= fill_next;
            ts_reg         <= ts_next;
            type_reg       <= type_next;
            chan_reg       <= chan_next;
            size_reg       <= size_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/h264fua_queue.sv
// Short queue of classified entries between front and back ends.
`default_nettype none
module h264fua_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire h264fua_pkg::entry_t  push_entry,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      not_empty,
    output h264fua_pkg::entry_t       head
);
    import h264fua_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    entry_t                slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_BITS:0]     count_reg, count_next;

    assign full      = (count_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (PTR_BITS+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (PTR_BITS+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/h264fua_back.sv
// Back end: expands queued entries into payload bytes in an output register.
`default_nettype none
module h264fua_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 avail,
    input  wire h264fua_pkg::entry_t  head,
    output logic                      pop,
    input  wire logic [6:0]           header_bytes,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                pay_byte,
    output logic                      pkt_first,
    output logic                      pkt_last,
    output logic [14:0]               pkt_size,
    output logic                      marker,
    output logic [31:0]               out_timestamp,
    output logic [7:0]                out_type,
    output logic                      out_channel
);
    import h264fua_pkg::*;

    localparam logic [1:0] PH_IND  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic        valid_reg, valid_next;
    logic        load;
    logic [7:0]  byte_sel;
    logic        first_sel, last_sel;

    logic [7:0]  byte_reg;
    logic        first_reg, last_reg, mark_reg, chan_reg;
    logic [14:0] size_reg;
    logic [31:0] ts_reg;
    logic [7:0]  type_reg;

    assign load = avail && (!valid_reg || out_ready);

    always_comb
    begin
        byte_sel   = head.data;
        first_sel  = head.first;
        last_sel   = head.last;
        phase_next = phase_reg;
        pop        = 1'b0;
        if (head.triple)
        begin
            case (phase_reg)
                PH_IND:
                begin
                    byte_sel  = head.ind;
                    first_sel = 1'b1;
                    last_sel  = 1'b0;
                end
                PH_HDR:
                begin
                    byte_sel  = head.hdr;
                    first_sel = 1'b0;
                    last_sel  = 1'b0;
                end
                default:
                begin
                    byte_sel  = head.data;
                    first_sel = 1'b0;
                end
            endcase
        end
        if (load)
        begin
            if (!head.triple || phase_reg == PH_DATA)
            begin
                pop        = 1'b1;
                phase_next = PH_IND;
            end
            else
                phase_next = phase_reg + 2'd1;
        end
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= byte_sel;
            first_reg <= first_sel;
            last_reg  <= last_sel;
            mark_reg  <= head.mark;
            size_reg  <= {1'b0, head.size} + {8'd0, header_bytes};
            ts_reg    <= head.ts;
            type_reg  <= head.ftype;
            chan_reg  <= head.chan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IND;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid     = valid_reg;
    assign pay_byte      = byte_reg;
    assign pkt_first     = first_reg;
    assign pkt_last      = last_reg;
    assign pkt_size      = size_reg;
    assign marker        = mark_reg;
    assign out_timestamp = ts_reg;
    assign out_type      = type_reg;
    assign out_channel   = chan_reg;

endmodule
`default_nettype wire

FILE: rtl/h264fua_packetizer.sv
// Top level of the H.264 RTP packetizer with FU-A fragmentation.
// Path: an accepted byte is written into the queue, then loaded into the output register.
// Throughput: one input byte per cycle while the queue is not full; a fragment start
// yields three results (FU indicator, FU header, byte) from one queued entry.
// Reset: asynchronous active low; clears NAL state, queue and output valid.
`default_nettype none
module h264_fua_packetizer #(
    parameter int LENGTH_BITS = h264fua_pkg::LENGTH_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   nal_byte,
    input  wire logic         first_of_frame,
    input  wire logic [23:0]  frame_length,
    input  wire logic [31:0]  timestamp,
    input  wire logic [7:0]   frame_type,
    input  wire logic         channel,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        pay_byte,
    output logic              pkt_first,
    output logic              pkt_last,
    output logic [14:0]       pkt_size,
    output logic              marker,
    output logic [31:0]       out_timestamp,
    output logic [7:0]        out_type,
    output logic              out_channel,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [13:0]  cfg_data
);
    import h264fua_pkg::*;

    logic [13:0] max_payload_reg;
    logic [6:0]  header_bytes_reg;
    logic        accept, push, pop, full, not_empty;
    entry_t      push_entry, head;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg  <= MAX_PAYLOAD_RESET;
            header_bytes_reg <= HEADER_BYTES_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_PAYLOAD:  max_payload_reg  <= cfg_data;
                REG_HEADER_BYTES: header_bytes_reg <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    h264fua_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .nal_byte       (nal_byte),
        .first_of_frame (first_of_frame),
        .frame_length   (frame_length),
        .timestamp      (timestamp),
        .frame_type     (frame_type),
        .channel        (channel),
        .max_payload    (max_payload_reg),
        .push           (push),
        .entry          (push_entry)
    );

    h264fua_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    h264fua_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .avail         (not_empty),
        .head          (head),
        .pop           (pop),
        .header_bytes  (header_bytes_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pay_byte      (pay_byte),
        .pkt_first     (pkt_first),
        .pkt_last      (pkt_last),
        .pkt_size      (pkt_size),
        .marker        (marker),
        .out_timestamp (out_timestamp),
        .out_type      (out_type),
        .out_channel   (out_channel)
    );

endmodule
`default_nettype wire
